// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset (rst_n)
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// cons must hold in the same cycle as ante
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types, sizes and helpers of the indexed doubly linked list unit
// ----------------------------------------------------------------------------
package idll_pkg;

  // pool sizing: slot numbers are 11 bits, so the pool stops at 1024 nodes
  localparam int CAPACITY = 1024;
  localparam int SLOTS    = (CAPACITY < 1024) ? CAPACITY : 1024;
  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int FILL_W   = $clog2(SLOTS + 1);

  // field widths
  localparam int SLOT_W   = 11;
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int IN_W     = 88;
  localparam int OUT_W    = 96;

  // null link
  localparam logic [SLOT_W-1:0] NIL = {SLOT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD       = 3'd0,
    CMD_SET_ENDS   = 3'd1,
    CMD_INS_AFTER  = 3'd2,
    CMD_INS_BEFORE = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_READ       = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2
  } status_t;

  // result word, last field (slot) in the lowest bits
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] slot_backward;
    logic [SLOT_W-1:0] slot_forward;
    logic [VAL_W-1:0]  slot_value;
    logic [SLOT_W-1:0] slot;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // slot is allocated: non-negative and below the fill count
  function automatic logic slot_live(input logic [SLOT_W-1:0] s,
                                     input logic [FILL_W-1:0] fill);
    return !s[SLOT_W-1] && (s < SLOT_W'(fill));
  endfunction

endpackage

// ===== design/indexed_doubly_linked_list_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_unit
// Doubly linked list in value / forward / backward node memories by slot
// ----------------------------------------------------------------------------
// sequence: the node read at accept, then two write passes through the single
//   write port of each link memory, then the output load, which waits while the
//   output is stalled; no new command is taken until the result word is loaded
// reset: synchronous, active low; head and tail go null, fill count to zero;
//   node memories are not cleared and need no clearing pass
`include "assert_macros.svh"

module indexed_doubly_linked_list_unit
  import idll_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // command words
  input  logic             in_tvalid,
  output logic             in_tready,
  // position, value, link_forward, link_backward, new_head, new_tail
  input  logic [IN_W-1:0]  in_tdata,
  // cmd
  input  logic [CMD_W-1:0] in_tuser,
  // result words
  output logic             out_tvalid,
  input  logic             out_tready,
  // slot, slot_value, slot_forward, slot_backward, head_slot, tail_slot, status
  output logic [OUT_W-1:0] out_tdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_EX, ST_WB, ST_OUT} state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [SLOT_W-1:0]   pos_r, lf_r, lb_r, nh_r, nt_r;
  logic [VAL_W-1:0]    val_r;
  logic [SLOT_W-1:0]   head_r, tail_r, head_nxt, tail_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt, fill_inc;
  res_t                res_r, res_nxt;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  // second write pass, held from the execute cycle
  logic                fb_we_r, fb_we_nxt, bb_we_r, bb_we_nxt;
  logic [ADDR_W-1:0]   fb_addr_r, fb_addr_nxt, bb_addr_r, bb_addr_nxt;
  logic [SLOT_W-1:0]   fb_data_r, fb_data_nxt, bb_data_r, bb_data_nxt;

  // first write pass, straight from the execute logic
  logic                va_we, fa_we, ba_we;
  logic [ADDR_W-1:0]   fa_addr, ba_addr;
  logic [SLOT_W-1:0]   fa_data, ba_data;

  // memory ports
  logic                v_we, f_we, b_we;
  logic [ADDR_W-1:0]   f_waddr, b_waddr, rd_addr;
  logic [SLOT_W-1:0]   f_wdata, b_wdata;
  logic [VAL_W-1:0]    rd_v;
  logic [SLOT_W-1:0]   rd_f, rd_b;

  logic [SLOT_W-1:0]   n_slot;
  logic [ADDR_W-1:0]   n_addr;
  logic                full, pos_live, pos_nil;

  // node read is issued at accept with the incoming position
  assign rd_addr  = in_tdata[ADDR_W-1:0];

  assign n_slot   = SLOT_W'(fill_r);
  assign n_addr   = fill_r[ADDR_W-1:0];
  assign fill_inc = fill_r + 1'b1;
  assign full     = (fill_r == FILL_W'(SLOTS));
  assign pos_live = slot_live(pos_r, fill_r);
  assign pos_nil  = (pos_r == NIL);

  // execute: decide the command, first write pass and second write pass
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    res_nxt     = '{status: STS_OK, tail_slot: NIL, head_slot: NIL,
                    slot_backward: NIL, slot_forward: NIL,
                    slot_value: '0, slot: NIL};
    va_we       = 1'b0;
    fa_we       = 1'b0;
    fa_addr     = n_addr;
    fa_data     = NIL;
    ba_we       = 1'b0;
    ba_addr     = n_addr;
    ba_data     = NIL;
    fb_we_nxt   = 1'b0;
    fb_addr_nxt = n_addr;
    fb_data_nxt = n_slot;
    bb_we_nxt   = 1'b0;
    bb_addr_nxt = n_addr;
    bb_data_nxt = n_slot;

    case (cmd_r)
      CMD_LOAD: begin
        if (full) begin
          res_nxt.status = STS_FULL;
        end else begin
          res_nxt.slot = n_slot;
          va_we        = 1'b1;
          fa_we        = 1'b1;
          fa_data      = lf_r;
          ba_we        = 1'b1;
          ba_data      = lb_r;
          fill_nxt     = fill_inc;
        end
      end
      CMD_SET_ENDS: begin
        if ((nh_r == NIL || slot_live(nh_r, fill_r)) &&
            (nt_r == NIL || slot_live(nt_r, fill_r))) begin
          head_nxt = nh_r;
          tail_nxt = nt_r;
        end else begin
          res_nxt.status = STS_BAD;
        end
      end
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if (!pos_nil && !pos_live) begin
          res_nxt.status = STS_BAD;
        end else if (full) begin
          res_nxt.status = STS_FULL;
        end else begin
          fill_nxt     = fill_inc;
          va_we        = 1'b1;
          res_nxt.slot = n_slot;
          if (cmd_r == CMD_INS_AFTER) begin
            if (pos_nil) begin
              // new head
              fa_we       = 1'b1;
              fa_data     = head_r;
              ba_we       = 1'b1;
              ba_data     = NIL;
              bb_we_nxt   = slot_live(head_r, fill_inc);
              bb_addr_nxt = head_r[ADDR_W-1:0];
              head_nxt    = n_slot;
            end else begin
              // splice between pos and its successor
              fa_we       = 1'b1;
              fa_data     = rd_f;
              ba_we       = slot_live(rd_f, fill_inc);
              ba_addr     = rd_f[ADDR_W-1:0];
              ba_data     = n_slot;
              bb_we_nxt   = 1'b1;
              bb_addr_nxt = n_addr;
              bb_data_nxt = pos_r;
              fb_we_nxt   = 1'b1;
              fb_addr_nxt = pos_r[ADDR_W-1:0];
            end
            if (pos_r == tail_r) begin
              tail_nxt = n_slot;
            end
          end else begin
            if (pos_nil) begin
              // new tail
              ba_we       = 1'b1;
              ba_data     = tail_r;
              fa_we       = 1'b1;
              fa_data     = NIL;
              fb_we_nxt   = slot_live(tail_r, fill_inc);
              fb_addr_nxt = tail_r[ADDR_W-1:0];
              tail_nxt    = n_slot;
            end else begin
              // splice between the predecessor and pos
              fa_we       = 1'b1;
              fa_data     = pos_r;
              ba_we       = 1'b1;
              ba_data     = rd_b;
              fb_we_nxt   = slot_live(rd_b, fill_inc);
              fb_addr_nxt = rd_b[ADDR_W-1:0];
              bb_we_nxt   = 1'b1;
              bb_addr_nxt = pos_r[ADDR_W-1:0];
            end
            if (pos_r == head_r) begin
              head_nxt = n_slot;
            end
          end
        end
      end
      CMD_DELETE: begin
        if (!pos_live) begin
          res_nxt.status = STS_BAD;
        end else begin
          res_nxt.slot       = pos_r;
          res_nxt.slot_value = rd_v;
          // join the neighbours, moving an end where a neighbour link is not live
          if (slot_live(rd_b, fill_r)) begin
            fa_we   = 1'b1;
            fa_addr = rd_b[ADDR_W-1:0];
            fa_data = rd_f;
          end else begin
            head_nxt = slot_live(rd_f, fill_r) ? rd_f : NIL;
          end
          if (slot_live(rd_f, fill_r)) begin
            ba_we   = 1'b1;
            ba_addr = rd_f[ADDR_W-1:0];
            ba_data = rd_b;
          end else begin
            tail_nxt = slot_live(rd_b, fill_r) ? rd_b : NIL;
          end
        end
      end
      CMD_READ: begin
        if (!pos_live) begin
          res_nxt.status = STS_BAD;
        end else begin
          res_nxt.slot          = pos_r;
          res_nxt.slot_value    = rd_v;
          res_nxt.slot_forward  = rd_f;
          res_nxt.slot_backward = rd_b;
        end
      end
      default: begin
        res_nxt.status = STS_BAD;
      end
    endcase

    res_nxt.head_slot = head_nxt;
    res_nxt.tail_slot = tail_nxt;
  end

  // write port selection: first pass in execute, second pass after it
  always_comb begin
    v_we    = (state_r == ST_EX) && va_we;
    f_we    = 1'b0;
    f_waddr = fa_addr;
    f_wdata = fa_data;
    b_we    = 1'b0;
    b_waddr = ba_addr;
    b_wdata = ba_data;
    case (state_r)
      ST_EX: begin
        f_we = fa_we;
        b_we = ba_we;
      end
      ST_WB: begin
        f_we    = fb_we_r;
        f_waddr = fb_addr_r;
        f_wdata = fb_data_r;
        b_we    = bb_we_r;
        b_waddr = bb_addr_r;
        b_wdata = bb_data_r;
      end
      default: begin
        f_we = 1'b0;
        b_we = 1'b0;
      end
    endcase
  end

  // node memories
  idll_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_values (
    .clk   (clk),
    .we    (v_we),
    .waddr (n_addr),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (rd_v)
  );

  idll_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_forward (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (rd_addr),
    .rdata (rd_f)
  );

  idll_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_backward (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (rd_addr),
    .rdata (rd_b)
  );

  // sequencer, list ends, fill count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      fill_r      <= '0;
      fb_we_r     <= 1'b0;
      bb_we_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result word taken, unless a new one is loaded in its place
      if (out_valid_r && out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= cmd_t'(in_tuser);
            pos_r   <= in_tdata[10:0];
            val_r   <= in_tdata[42:11];
            lf_r    <= in_tdata[53:43];
            lb_r    <= in_tdata[64:54];
            nh_r    <= in_tdata[75:65];
            nt_r    <= in_tdata[86:76];
            state_r <= ST_EX;
          end
        end
        ST_EX: begin
          head_r    <= head_nxt;
          tail_r    <= tail_nxt;
          fill_r    <= fill_nxt;
          res_r     <= res_nxt;
          fb_we_r   <= fb_we_nxt;
          fb_addr_r <= fb_addr_nxt;
          fb_data_r <= fb_data_nxt;
          bb_we_r   <= bb_we_nxt;
          bb_addr_r <= bb_addr_nxt;
          bb_data_r <= bb_data_nxt;
          state_r   <= ST_WB;
        end
        ST_WB: begin
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= OUT_W'(res_r);
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `ASSERT_IMPL(fill_range_a, 1'b1, fill_r <= FILL_W'(SLOTS))
  `ASSERT_NEXT(fill_hold_a, state_r != ST_EX, $stable(fill_r))
  `ASSERT_IMPL(head_live_a, 1'b1, (head_r == NIL) || slot_live(head_r, fill_r))
  `ASSERT_IMPL(tail_live_a, 1'b1, (tail_r == NIL) || slot_live(tail_r, fill_r))
  `ASSERT_IMPL(wr_phase_a, v_we || f_we || b_we, (state_r == ST_EX) || (state_r == ST_WB))
  `ASSERT_NEXT(one_cmd_a, in_tvalid && in_tready, state_r == ST_EX)

endmodule

// ===== design/idll_ram.sv =====
// ----------------------------------------------------------------------------
// idll_ram
// Generic simple dual-port RAM, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module idll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/idll_result_checker.sv =====
// ----------------------------------------------------------------------------
// idll_result_checker
// Watches the command and result streams of the linked list unit, keeps its
// own copy of the node tables, head, tail and fill count, predicts the result
// word of every accepted command and compares it field by field
// ----------------------------------------------------------------------------
module idll_result_checker
  import idll_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0] in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             run_over,
  output int               mismatch_count
);

  typedef logic signed [SLOT_W-1:0] link_t;

  // command word, last field (position) in the lowest bits
  typedef struct packed {
    logic             pad;
    link_t            new_tail;
    link_t            new_head;
    link_t            link_bwd;
    link_t            link_fwd;
    logic [VAL_W-1:0] value;
    link_t            position;
  } cmd_word_t;

  localparam link_t NO_LINK = -1;

  // shadow of the node tables and list ends
  logic [VAL_W-1:0] node_val  [SLOTS];
  link_t            node_next [SLOTS];
  link_t            node_prev [SLOTS];
  int               fill;
  link_t            list_head;
  link_t            list_tail;

  res_t             expected_results [$];
  res_t             got;
  res_t             want;
  int               words_seen;
  bit               leftovers_checked;

  // one line per mismatch, every one counted
  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
    $display("mismatch at result word %0d: %s got %0h expected %0h",
             words_seen, what, got_v, exp_v);
    mismatch_count++;
  endtask

  // slot handed out already
  function automatic bit allocated(input link_t s);
    return (s >= 0) && (int'(s) < fill);
  endfunction

  // apply one command to the shadow state and build its result word
  function automatic res_t apply_list_command(input logic [CMD_W-1:0] op,
                                              input logic [IN_W-1:0] raw);
    cmd_word_t w;
    link_t     p;
    link_t     nb;
    link_t     pv;
    int        n;
    res_t      r;
    w = cmd_word_t'(raw);
    p = w.position;
    r.slot          = NO_LINK;
    r.slot_value    = '0;
    r.slot_forward  = NO_LINK;
    r.slot_backward = NO_LINK;
    r.status        = STS_OK;
    case (op)
      CMD_LOAD: begin
        if (fill >= SLOTS) begin
          r.status = STS_FULL;
        end else begin
          // links go in unchecked
          node_val[fill]  = w.value;
          node_next[fill] = w.link_fwd;
          node_prev[fill] = w.link_bwd;
          r.slot = link_t'(fill);
          fill++;
        end
      end
      CMD_SET_ENDS: begin
        if ((w.new_head == NO_LINK || allocated(w.new_head)) &&
            (w.new_tail == NO_LINK || allocated(w.new_tail))) begin
          list_head = w.new_head;
          list_tail = w.new_tail;
        end else begin
          r.status = STS_BAD;
        end
      end
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        // index check ahead of the pool check
        if (p != NO_LINK && !allocated(p)) begin
          r.status = STS_BAD;
        end else if (fill >= SLOTS) begin
          r.status = STS_FULL;
        end else begin
          // new slot is live from here on, before any link is followed
          n = fill;
          fill++;
          node_val[n] = w.value;
          if (op == CMD_INS_AFTER) begin
            if (p == NO_LINK) begin
              node_next[n] = list_head;
              node_prev[n] = NO_LINK;
              if (allocated(list_head))
                node_prev[list_head] = link_t'(n);
              list_head = link_t'(n);
            end else begin
              nb = node_next[p];
              node_next[n] = nb;
              if (allocated(nb))
                node_prev[nb] = link_t'(n);
              node_prev[n] = p;
              node_next[p] = link_t'(n);
            end
            if (p == list_tail)
              list_tail = link_t'(n);
          end else begin
            if (p == NO_LINK) begin
              node_prev[n] = list_tail;
              node_next[n] = NO_LINK;
              if (allocated(list_tail))
                node_next[list_tail] = link_t'(n);
              list_tail = link_t'(n);
            end else begin
              pv = node_prev[p];
              node_next[n] = p;
              if (allocated(pv))
                node_next[pv] = link_t'(n);
              node_prev[n] = pv;
              node_prev[p] = link_t'(n);
            end
            if (p == list_head)
              list_head = link_t'(n);
          end
          r.slot = link_t'(n);
        end
      end
      CMD_DELETE: begin
        if (!allocated(p)) begin
          r.status = STS_BAD;
        end else begin
          // join the neighbours, a dead link moves the end instead
          pv = node_prev[p];
          nb = node_next[p];
          r.slot       = p;
          r.slot_value = node_val[p];
          if (allocated(pv))
            node_next[pv] = nb;
          else
            list_head = allocated(nb) ? nb : NO_LINK;
          if (allocated(nb))
            node_prev[nb] = pv;
          else
            list_tail = allocated(pv) ? pv : NO_LINK;
        end
      end
      CMD_READ: begin
        if (!allocated(p)) begin
          r.status = STS_BAD;
        end else begin
          r.slot          = p;
          r.slot_value    = node_val[p];
          r.slot_forward  = node_next[p];
          r.slot_backward = node_prev[p];
        end
      end
      default: r.status = STS_BAD;
    endcase
    r.head_slot = list_head;
    r.tail_slot = list_tail;
    return r;
  endfunction

  // predict on every accepted command, compare on every accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      fill      = 0;
      list_head = NO_LINK;
      list_tail = NO_LINK;
      expected_results.delete();
      words_seen        = 0;
      leftovers_checked = 1'b0;
      mismatch_count    = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_list_command(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("word with nothing expected", got.slot_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.slot !== want.slot)
            report_mismatch("slot", 32'(got.slot), 32'(want.slot));
          if (got.slot_value !== want.slot_value)
            report_mismatch("slot_value", got.slot_value, want.slot_value);
          if (got.slot_forward !== want.slot_forward)
            report_mismatch("slot_forward", 32'(got.slot_forward),
                            32'(want.slot_forward));
          if (got.slot_backward !== want.slot_backward)
            report_mismatch("slot_backward", 32'(got.slot_backward),
                            32'(want.slot_backward));
          if (got.head_slot !== want.head_slot)
            report_mismatch("head_slot", 32'(got.head_slot), 32'(want.head_slot));
          if (got.tail_slot !== want.tail_slot)
            report_mismatch("tail_slot", 32'(got.tail_slot), 32'(want.tail_slot));
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        words_seen++;
      end
      // anything still owed at the end is lost
      if (run_over && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_results.size() != 0)
          report_mismatch("words never delivered", 0, expected_results.size());
      end
    end
  end

endmodule

// ===== dv/indexed_doubly_linked_list_unit_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_unit_tb
// Drives list commands into the unit: a directed opening over empty lists,
// end inserts, middle deletes, bad indices and unknown commands, then random
// commands, bad operands and reserved codes among them, until the pool is full
// and a stretch past full, with random idling on both streams, one long output
// stall and a full drain midway. The checker beside the unit predicts and
// compares every result word.
module indexed_doubly_linked_list_unit_tb;
  import idll_pkg::*;

  typedef logic signed [SLOT_W-1:0] link_t;

  typedef struct packed {
    logic             pad;
    link_t            new_tail;
    link_t            new_head;
    link_t            link_bwd;
    link_t            link_fwd;
    logic [VAL_W-1:0] value;
    link_t            position;
  } cmd_word_t;

  localparam link_t            NO_LINK     = -1;
  localparam logic [CMD_W-1:0] CMD_RSVD_A  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B  = 3'd7;
  localparam int               CYCLE_LIMIT = 800000;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0] in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             run_over   = 1'b0;
  int               mismatch_count;

  int               sent        = 0;
  int               received    = 0;
  int               fill_shadow = 0;
  int               tx_calm     = 0;
  int               rx_calm     = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_doubly_linked_list_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  idll_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .run_over       (run_over),
    .mismatch_count (mismatch_count)
  );

  // words moved on each stream
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sent <= sent + 1;
      if (out_tvalid && out_tready)
        received <= received + 1;
    end
  end

  // idle length: mostly none or short, now and then long, with calm runs
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // slot operand: mostly allocated, recent slots favoured, some null or bad
  function automatic link_t any_slot();
    int r;
    int span;
    r = $urandom_range(0, 99);
    if (r < 10)
      return NO_LINK;
    if (r < 20)
      return link_t'($urandom_range(0, 1023));
    if (r < 23)
      return link_t'($urandom);
    if (fill_shadow == 0)
      return NO_LINK;
    span = (fill_shadow > 16) ? 16 : fill_shadow;
    if (r < 60)
      return link_t'(fill_shadow - 1 - int'($urandom_range(0, span - 1)));
    return link_t'($urandom_range(0, fill_shadow - 1));
  endfunction

  // offer one command word after a random idle, wait for it to be taken
  task automatic issue(input logic [CMD_W-1:0] op, input link_t pos,
                       input logic [VAL_W-1:0] val, input link_t lf,
                       input link_t lb, input link_t nh, input link_t nt);
    cmd_word_t w;
    int        gap;
    w.pad      = 1'b0;
    w.new_tail = nt;
    w.new_head = nh;
    w.link_bwd = lb;
    w.link_fwd = lf;
    w.value    = val;
    w.position = pos;
    // track slot allocation to steer later operands
    case (op)
      CMD_LOAD: begin
        if (fill_shadow < SLOTS)
          fill_shadow++;
      end
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if ((pos == NO_LINK || (pos >= 0 && int'(pos) < fill_shadow)) &&
            fill_shadow < SLOTS)
          fill_shadow++;
      end
      default: ;
    endcase
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(w);
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // random command, alloc_pct of them loads and inserts
  task automatic random_command(input int alloc_pct);
    int               r;
    logic [CMD_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      r  = $urandom_range(0, 9);
      op = (r < 2) ? CMD_LOAD : (r < 6) ? CMD_INS_AFTER : CMD_INS_BEFORE;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 35)
        op = CMD_DELETE;
      else if (r < 70)
        op = CMD_READ;
      else if (r < 93)
        op = CMD_SET_ENDS;
      else
        op = r[0] ? CMD_RSVD_A : CMD_RSVD_B;
    end
    issue(op, any_slot(), $urandom, any_slot(), any_slot(), any_slot(), any_slot());
  endtask

  // result side: random stalls, one long hold-off to back the unit up
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && received >= 300) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        gap = idle_len(rx_calm);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // cycle limit
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int issued;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty pool: every index is bad
    issue(CMD_READ,       0,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_DELETE,     NO_LINK, $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_SET_ENDS,   NO_LINK, $urandom,     NO_LINK, NO_LINK, 0,       NO_LINK);
    issue(CMD_INS_AFTER,  5,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    // insert into an empty list, then remove the only node
    issue(CMD_INS_AFTER,  NO_LINK, 32'h7fffffff, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_DELETE,     0,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_INS_BEFORE, NO_LINK, 32'h80000000, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    // grow around slot 1 and at both ends
    issue(CMD_INS_AFTER,  1,       32'h00000000, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_INS_BEFORE, 1,       32'hffffffff, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_INS_AFTER,  NO_LINK, 32'h00000001, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_INS_BEFORE, NO_LINK, 32'h55555555, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    // loaded nodes keep whatever links they are given
    issue(CMD_LOAD,       NO_LINK, 32'haaaaaaaa, 1023,    NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_LOAD,       NO_LINK, 32'h12345678, NO_LINK, 1023,    NO_LINK, NO_LINK);
    issue(CMD_READ,       6,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_READ,       2,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    // delete in the middle, at the head and at the tail
    issue(CMD_DELETE,     2,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_DELETE,     4,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_DELETE,     5,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    // ends: unallocated, both null, then valid
    issue(CMD_SET_ENDS,   NO_LINK, $urandom,     NO_LINK, NO_LINK, 1023,    NO_LINK);
    issue(CMD_SET_ENDS,   NO_LINK, $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_SET_ENDS,   NO_LINK, $urandom,     NO_LINK, NO_LINK, 3,       1);
    // node whose links point outside the pool
    issue(CMD_DELETE,     6,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_INS_BEFORE, 1023,    $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_RSVD_A,     1,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    issue(CMD_RSVD_B,     1,       $urandom,     NO_LINK, NO_LINK, NO_LINK, NO_LINK);

    // mostly allocating until the pool is full, one pause for a full drain
    issued = 0;
    while (fill_shadow < SLOTS) begin
      random_command(85);
      issued++;
      if (issued == 500) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (received != sent) @(posedge clk);
      end
    end

    // past full: allocations refused, lists still edited and read
    repeat (250) random_command(30);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (received != sent) @(posedge clk);
    repeat (20) @(posedge clk);
    run_over <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/idll_pkg.sv
design/idll_ram.sv
design/indexed_doubly_linked_list_unit.sv
dv/idll_result_checker.sv
dv/indexed_doubly_linked_list_unit_tb.sv
